/* rtl/nfba_pkg.sv */
// ----------------------------------------------------------------------------
// Next-fit allocator package
// Shared defaults, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package nfba_pkg;

    // Default pool and header sizes in bytes.
    localparam int unsigned POOL_BYTES_DEF   = 65536;
    localparam int unsigned HEADER_BYTES_DEF = 24;

    // Command codes of an input word.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_REFUSED  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_INIT0,
        ST_INIT1,
        ST_IDLE,
        ST_A_CHK,
        ST_A_SPL1,
        ST_A_SPL2,
        ST_F_H,
        ST_F_B,
        ST_F_N,
        ST_F_NN,
        ST_F_WC,
        ST_RESP
    } state_t;

endpackage

/* rtl/nfba_hdr_mem.sv */
// ----------------------------------------------------------------------------
// Header store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module nfba_hdr_mem #(
    parameter int unsigned DEPTH = 8192,
    parameter int unsigned AW    = 13,
    parameter int unsigned DW    = 44
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/next_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Next-fit block allocator
// Allocate scans ring headers from the rover, plus ST_A_SPL1 and ST_A_SPL2 on
// a split; free checks the header and merges with free neighbours.
// One word at a time: the next word is taken at the edge after the result is
// registered, and a stalled result holds the input off.
// After reset ST_INIT0 and ST_INIT1 write the sentinel and the first free
// header; no word is taken until then.
// ----------------------------------------------------------------------------
module next_fit_block_allocator_unit #(
    parameter int unsigned POOL_BYTES   = nfba_pkg::POOL_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = nfba_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [16:0] request_bytes,
    input  logic [15:0] block_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] payload_address
);

    import nfba_pkg::*;

    localparam int unsigned UNITS     = (POOL_BYTES + 7) / 8;
    localparam int unsigned UW        = $clog2(UNITS);
    localparam int unsigned HDR_UNITS = (HEADER_BYTES + 7) / 8;
    localparam int unsigned HDR       = HDR_UNITS * 8;
    localparam int unsigned SPLIT_MIN = HDR + 4;
    localparam int unsigned SW        = $clog2(UNITS * 8 + 1);
    localparam int unsigned CW        = ((SW > 18) ? SW : 18) + 2;
    localparam int unsigned FIRST_SZ  = UNITS * 8 - 2 * HDR;

    typedef struct packed {
        logic          valid;
        logic          free;
        logic [SW-1:0] size;
        logic [UW-1:0] next;
        logic [UW-1:0] prev;
    } entry_t;

    localparam int unsigned DW = $bits(entry_t);

    state_t        state_reg, state_next;
    logic [UW-1:0] cur_reg, cur_next;
    logic [UW-1:0] n_reg, n_next;
    logic [UW-1:0] rover_reg, rover_next;
    logic [17:0]   want_reg, want_next;
    entry_t        ent_reg, ent_next;
    logic          mrg_reg, mrg_next;
    status_t       res_st_reg, res_st_next;
    logic [15:0]   res_adr_reg, res_adr_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_st_reg, out_st_next;
    logic [15:0]   out_adr_reg, out_adr_next;

    logic          wr_en;
    logic [UW-1:0] wr_addr;
    entry_t        wr_ent;
    logic [UW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    entry_t        rd_ent;

    logic [CW-1:0] diff;
    logic [CW-1:0] nu_wide;
    logic [31:0]   free_off;
    logic [31:0]   pay_off;
    logic [31:0]   h_wide;

    assign rd_ent = entry_t'(rd_data);

    nfba_hdr_mem #(
        .DEPTH (UNITS),
        .AW    (UW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Arithmetic shared by the allocate path and the free address check.
    always_comb
    begin
        diff     = CW'(rd_ent.size) - CW'(want_reg);
        nu_wide  = CW'(cur_reg) + CW'(HDR_UNITS) + CW'(want_reg >> 3);
        pay_off  = (32'(cur_reg) << 3) + 32'(HDR);
        free_off = 32'(block_address) - 32'(HDR);
        h_wide   = free_off >> 3;
    end

    // State and data registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT0;
            rover_reg     <= UW'(HDR_UNITS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        n_reg       <= n_next;
        want_reg    <= want_next;
        ent_reg     <= ent_next;
        mrg_reg     <= mrg_next;
        res_st_reg  <= res_st_next;
        res_adr_reg <= res_adr_next;
        out_st_reg  <= out_st_next;
        out_adr_reg <= out_adr_next;
    end

    // Sequencer: next state, memory accesses and result.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        rover_next     = rover_reg;
        want_next      = want_reg;
        ent_next       = ent_reg;
        mrg_next       = mrg_reg;
        res_st_next    = res_st_reg;
        res_adr_next   = res_adr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_st_next    = out_st_reg;
        out_adr_next   = out_adr_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_reg;
        wr_ent         = ent_reg;
        rd_addr        = cur_reg;

        unique case (state_reg)
            ST_INIT0:
            begin
                // Sentinel header at unit zero.
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_ent      = '{valid: 1'b1, free: 1'b0, size: '0,
                                next: UW'(HDR_UNITS), prev: UW'(HDR_UNITS)};
                state_next  = ST_INIT1;
            end

            ST_INIT1:
            begin
                // One free block spanning the rest of the pool.
                wr_en       = 1'b1;
                wr_addr     = UW'(HDR_UNITS);
                wr_ent      = '{valid: 1'b1, free: 1'b1, size: SW'(FIRST_SZ),
                                next: '0, prev: '0};
                state_next  = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_adr_next = '0;
                    if (command == CMD_ALLOC)
                    begin
                        want_next  = ({1'b0, request_bytes} + 18'd7) & ~18'd7;
                        cur_next   = rover_reg;
                        rd_addr    = rover_reg;
                        state_next = ST_A_CHK;
                    end
                    else if (32'(block_address) < 32'(HDR) || block_address[2:0] != 3'd0
                             || h_wide == 32'd0 || h_wide >= 32'(UNITS))
                    begin
                        res_st_next = STATUS_REFUSED;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        cur_next   = UW'(h_wide);
                        rd_addr    = UW'(h_wide);
                        state_next = ST_F_H;
                    end
                end
            end

            ST_A_CHK:
            begin
                // Examine one header of the ring per cycle.
                if (rd_ent.free && CW'(rd_ent.size) > CW'(want_reg))
                begin
                    rover_next   = cur_reg;
                    res_st_next  = STATUS_DONE;
                    res_adr_next = pay_off[15:0];
                    if (diff >= CW'(SPLIT_MIN) && nu_wide < CW'(UNITS))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = UW'(nu_wide);
                        wr_ent     = '{valid: 1'b1, free: 1'b1,
                                       size: SW'(diff - CW'(HDR)),
                                       next: rd_ent.next, prev: cur_reg};
                        rd_addr    = rd_ent.next;
                        ent_next   = '{valid: 1'b1, free: 1'b0, size: SW'(want_reg),
                                       next: UW'(nu_wide), prev: rd_ent.prev};
                        n_next     = rd_ent.next;
                        state_next = ST_A_SPL1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = cur_reg;
                        wr_ent      = rd_ent;
                        wr_ent.free = 1'b0;
                        state_next  = ST_RESP;
                    end
                end
                else if (rd_ent.next == rover_reg)
                begin
                    res_st_next  = STATUS_NO_SPACE;
                    res_adr_next = '0;
                    state_next   = ST_RESP;
                end
                else
                begin
                    cur_next = rd_ent.next;
                    rd_addr  = rd_ent.next;
                end
            end

            ST_A_SPL1:
            begin
                // Link the following block back to the split remainder.
                wr_en       = 1'b1;
                wr_addr     = n_reg;
                wr_ent      = rd_ent;
                wr_ent.prev = ent_reg.next;
                state_next  = ST_A_SPL2;
            end

            ST_A_SPL2:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                wr_ent     = ent_reg;
                state_next = ST_RESP;
            end

            ST_F_H:
            begin
                if (!rd_ent.valid || rd_ent.free)
                begin
                    res_st_next = STATUS_REFUSED;
                    state_next  = ST_RESP;
                end
                else
                begin
                    ent_next   = rd_ent;
                    rd_addr    = rd_ent.prev;
                    state_next = ST_F_B;
                end
            end

            ST_F_B:
            begin
                // Merge with a free block before, retiring this header.
                mrg_next   = rd_ent.free;
                n_next     = ent_reg.next;
                rd_addr    = ent_reg.next;
                state_next = ST_F_N;
                if (rd_ent.free)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = cur_reg;
                    wr_ent       = ent_reg;
                    wr_ent.valid = 1'b0;
                    ent_next     = '{valid: 1'b1, free: 1'b1,
                                     size: SW'(CW'(rd_ent.size) + CW'(ent_reg.size)
                                               + CW'(HDR)),
                                     next: ent_reg.next, prev: rd_ent.prev};
                    cur_next     = ent_reg.prev;
                    if (rover_reg == cur_reg)
                    begin
                        rover_next = ent_reg.prev;
                    end
                end
            end

            ST_F_N:
            begin
                // Merge with a free block after, or relink it.
                if (rd_ent.free && n_reg != cur_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = n_reg;
                    wr_ent        = rd_ent;
                    wr_ent.valid  = 1'b0;
                    ent_next.size = SW'(CW'(ent_reg.size) + CW'(rd_ent.size) + CW'(HDR));
                    ent_next.next = rd_ent.next;
                    n_next        = rd_ent.next;
                    rd_addr       = rd_ent.next;
                    if (rover_reg == n_reg)
                    begin
                        rover_next = cur_reg;
                    end
                    state_next    = ST_F_NN;
                end
                else
                begin
                    if (mrg_reg)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = n_reg;
                        wr_ent      = rd_ent;
                        wr_ent.prev = cur_reg;
                    end
                    state_next = ST_F_WC;
                end
            end

            ST_F_NN:
            begin
                wr_en       = 1'b1;
                wr_addr     = n_reg;
                wr_ent      = rd_ent;
                wr_ent.prev = cur_reg;
                state_next  = ST_F_WC;
            end

            ST_F_WC:
            begin
                wr_en        = 1'b1;
                wr_addr      = cur_reg;
                wr_ent       = ent_reg;
                wr_ent.valid = 1'b1;
                wr_ent.free  = 1'b1;
                res_st_next  = STATUS_DONE;
                res_adr_next = '0;
                state_next   = ST_RESP;
            end

            ST_RESP:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_adr_next   = res_adr_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ports.
    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_st_reg;
    assign payload_address = out_adr_reg;

endmodule
